@@ sv/rar_pkg.sv @@
// Package for the rational arithmetic reduce block: types, codes and constants.
`default_nettype none
package rar_pkg;

    localparam int WIDTH_DEFAULT = 32;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  command;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic signed [31:0] res_den;
        logic [1:0]         status;
    } out_beat_t;

endpackage
`default_nettype wire

@@ sv/rar_divider.sv @@
// Restoring 64-bit divider, one quotient bit per cycle, shared by both reductions.
`default_nettype none
module rar_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [63:0] divisor,
    output logic             done,
    output logic [63:0]      quotient,
    output logic [63:0]      remainder
);
    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[63]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

@@ sv/rational_arithmetic_reduce.sv @@
// Top level: rational add, subtract, multiply, divide with gcd reduction.
`default_nettype none
// Usage:
//   Raise start with a command beat on operands while busy is low; the beat is
//   taken at that edge and busy rises the next cycle. The result beat appears
//   on result for exactly one cycle with done high; the receiver cannot stall
//   it and busy falls in that same cycle.
//   Zero-denominator beats go straight to the output state. Otherwise the
//   cross products run on one shared 32x32 multiplier (three products, two
//   for divide), the signed sum follows on add and subtract, then the
//   Euclidean gcd on a 64-bit divider (up to about 93 remainder steps,
//   typically far fewer), then two divisions by the gcd and a range check.
//   The worst case is set by the number of remainder steps through the
//   shared divider.
//   One beat is in flight at a time. Reset returns the sequencer to idle and
//   drops any beat in progress; no result is produced for it.
module rational_arithmetic_reduce #(
    parameter int WIDTH = rar_pkg::WIDTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire rar_pkg::in_beat_t operands,
    output logic                  busy,
    output logic                  done,
    output rar_pkg::out_beat_t    result
);
    import rar_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_GCD_GO, S_GCD_WAIT,
        S_DN_GO, S_DN_WAIT, S_DD_GO, S_DD_WAIT, S_CHECK, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic        an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic        an_s_next, ad_s_next, bn_s_next, bd_s_next;
    logic [31:0] an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic [31:0] an_m_next, ad_m_next, bn_m_next, bd_m_next;
    logic [63:0] p0_reg, p1_reg, p0_next, p1_next;
    logic        p0_s_reg, p1_s_reg, p0_s_next, p1_s_next;
    logic [63:0] num_reg, den_reg, num_next, den_next;
    logic        num_s_reg, den_s_reg, num_s_next, den_s_next;
    logic [63:0] ga_reg, gb_reg, ga_next, gb_next;
    logic        done_reg, done_next;
    out_beat_t   res_reg, res_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        div_start;
    logic [63:0] div_dvd, div_dsr, div_q, div_r;
    logic        div_done;
    logic [63:0] lim;
    logic        num_fit, den_fit;

    rar_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    assign lim   = 64'd1 << (WIDTH - 1);

    always_comb
    begin
        mul_a = an_m_reg;
        mul_b = bd_m_reg;
        case (state_reg)
            S_MUL0:  begin mul_a = an_m_reg; mul_b = bd_m_reg; end
            S_MUL1:  begin mul_a = bn_m_reg; mul_b = ad_m_reg; end
            S_MUL2:  begin mul_a = an_m_reg; mul_b = bn_m_reg; end
            S_MUL3:
            begin
                // den = ad * bn for divide
                mul_a = ad_m_reg;
                mul_b = (cmd_reg == CMD_DIV) ? bn_m_reg : bd_m_reg;
            end
            default: begin mul_a = an_m_reg; mul_b = bd_m_reg; end
        endcase
    end

    always_comb
    begin
        num_fit = num_s_reg ? (num_reg <= lim) : (num_reg < lim);
        den_fit = den_s_reg ? (den_reg <= lim) : (den_reg < lim);
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        an_s_next = an_s_reg; ad_s_next = ad_s_reg;
        bn_s_next = bn_s_reg; bd_s_next = bd_s_reg;
        an_m_next = an_m_reg; ad_m_next = ad_m_reg;
        bn_m_next = bn_m_reg; bd_m_next = bd_m_reg;
        p0_next = p0_reg; p1_next = p1_reg;
        p0_s_next = p0_s_reg; p1_s_next = p1_s_reg;
        num_next = num_reg; den_next = den_reg;
        num_s_next = num_s_reg; den_s_next = den_s_reg;
        ga_next = ga_reg; gb_next = gb_reg;
        done_next = 1'b0;
        res_next = res_reg;
        div_start = 1'b0;
        div_dvd = ga_reg;
        div_dsr = gb_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = operands.command;
                    an_s_next = operands.a_num[31];
                    ad_s_next = operands.a_den[31];
                    bn_s_next = operands.b_num[31];
                    bd_s_next = operands.b_den[31];
                    an_m_next = operands.a_num[31] ? -operands.a_num : operands.a_num;
                    ad_m_next = operands.a_den[31] ? -operands.a_den : operands.a_den;
                    bn_m_next = operands.b_num[31] ? -operands.b_num : operands.b_num;
                    bd_m_next = operands.b_den[31] ? -operands.b_den : operands.b_den;
                    if (operands.a_den == '0 || operands.b_den == '0
                        || (operands.command == CMD_DIV && operands.b_num == '0))
                    begin
                        res_next  = '{res_num: '0, res_den: '0, status: ST_ZERO_DEN};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MUL0;
                    end
                end
            end
            S_MUL0:
            begin
                p0_next   = mul_p;
                p0_s_next = (an_s_reg != bd_s_reg) && (mul_p != '0);
                state_next = (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB) ? S_MUL1 : S_MUL2;
                if (cmd_reg == CMD_DIV)
                begin
                    num_next   = mul_p;
                    num_s_next = (an_s_reg != bd_s_reg) && (mul_p != '0);
                    state_next = S_MUL3;
                end
            end
            S_MUL1:
            begin
                p1_next = mul_p;
                // negate b for subtract, keep zero positive
                p1_s_next = ((bn_s_reg ^ (cmd_reg == CMD_SUB)) != ad_s_reg) && (mul_p != '0);
                state_next = S_MUL3;
            end
            S_MUL2:
            begin
                num_next   = mul_p;
                num_s_next = (an_s_reg != bn_s_reg) && (mul_p != '0);
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                den_next = mul_p;
                if (cmd_reg == CMD_DIV)
                begin
                    den_s_next = ad_s_reg != bn_s_reg;
                end
                else
                begin
                    den_s_next = ad_s_reg != bd_s_reg;
                end
                state_next = (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB) ? S_SUM : S_GCD_GO;
            end
            S_SUM:
            begin
                if (p0_s_reg == p1_s_reg)
                begin
                    num_next = p0_reg + p1_reg;
                    num_s_next = p0_s_reg;
                end
                else if (p0_reg >= p1_reg)
                begin
                    num_next = p0_reg - p1_reg;
                    num_s_next = p0_s_reg && (p0_reg != p1_reg);
                end
                else
                begin
                    num_next = p1_reg - p0_reg;
                    num_s_next = p1_s_reg;
                end
                state_next = S_GCD_GO;
            end
            S_GCD_GO:
            begin
                // gcd(num, den): den is nonzero, so start with a = den, b = num
                ga_next = den_reg;
                gb_next = num_reg;
                state_next = S_GCD_WAIT;
                if (num_reg != '0)
                begin
                    div_start = 1'b1;
                    div_dvd = den_reg;
                    div_dsr = num_reg;
                end
                else
                begin
                    state_next = S_DN_GO;
                end
            end
            S_GCD_WAIT:
            begin
                if (div_done)
                begin
                    ga_next = gb_reg;
                    gb_next = div_r;
                    if (div_r == '0)
                    begin
                        state_next = S_DN_GO;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_dvd = gb_reg;
                        div_dsr = div_r;
                    end
                end
            end
            S_DN_GO:
            begin
                div_start = 1'b1;
                div_dvd = num_reg;
                div_dsr = ga_reg;
                state_next = S_DN_WAIT;
            end
            S_DN_WAIT:
            begin
                if (div_done)
                begin
                    num_next = div_q;
                    state_next = S_DD_GO;
                end
            end
            S_DD_GO:
            begin
                div_start = 1'b1;
                div_dvd = den_reg;
                div_dsr = ga_reg;
                state_next = S_DD_WAIT;
            end
            S_DD_WAIT:
            begin
                if (div_done)
                begin
                    den_next = div_q;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (num_fit && den_fit)
                begin
                    res_next.res_num = num_s_reg ? -num_reg[31:0] : num_reg[31:0];
                    res_next.res_den = den_s_reg ? -den_reg[31:0] : den_reg[31:0];
                    res_next.status  = ST_OK;
                end
                else
                begin
                    res_next = '{res_num: '0, res_den: '0, status: ST_OVERFLOW};
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        an_s_reg <= an_s_next; ad_s_reg <= ad_s_next;
        bn_s_reg <= bn_s_next; bd_s_reg <= bd_s_next;
        an_m_reg <= an_m_next; ad_m_reg <= ad_m_next;
        bn_m_reg <= bn_m_next; bd_m_reg <= bd_m_next;
        p0_reg <= p0_next; p1_reg <= p1_next;
        p0_s_reg <= p0_s_next; p1_s_reg <= p1_s_next;
        num_reg <= num_next; den_reg <= den_next;
        num_s_reg <= num_s_next; den_s_reg <= den_s_next;
        ga_reg <= ga_next; gb_reg <= gb_next;
        res_reg <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

@@ bench/rational_arithmetic_reduce_checker.sv @@
// Checker for the rational arithmetic block: predicts each result and compares it.
module rational_arithmetic_reduce_checker #(
    parameter int WIDTH = rar_pkg::WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  rar_pkg::in_beat_t  operands,
    input  logic               done,
    input  rar_pkg::out_beat_t result,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen
);
    import rar_pkg::*;

    out_beat_t expected_q[$];

    // Signed values held in 65 bits so cross sums stay exact.
    function automatic out_beat_t reduce_fraction(in_beat_t b);
        out_beat_t r;
        logic signed [64:0] an, ad, bn, bd, num, den;
        logic [64:0] mn, md, x, y, t, lim;
        r = '0;
        an = b.a_num;
        ad = b.a_den;
        bn = b.b_num;
        bd = b.b_den;
        if (ad == 0 || bd == 0 || (cmd_t'(b.command) == CMD_DIV && bn == 0)) begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        case (cmd_t'(b.command))
            CMD_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
            CMD_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
            CMD_MUL: begin num = an * bn;           den = ad * bd; end
            default: begin num = an * bd;           den = ad * bn; end
        endcase
        mn = num < 0 ? -num : num;
        md = den < 0 ? -den : den;
        x = mn;
        y = md;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        mn = mn / x;
        md = md / x;
        lim = 65'd1 << (WIDTH - 1);
        if ((num < 0 ? mn > lim : mn >= lim) || (den < 0 ? md > lim : md >= lim)) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        r.res_num = num < 0 ? -mn[31:0] : mn[31:0];
        r.res_den = den < 0 ? -md[31:0] : md[31:0];
        r.status = ST_OK;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk) begin
        out_beat_t want;
        if (rst_n) begin
            if (done) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result beat %h", result);
                end else begin
                    want = expected_q.pop_front();
                    if (want.res_num !== result.res_num || want.res_den !== result.res_den
                            || want.status !== result.status) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: exp num %0d den %0d st %0d, got %0d %0d %0d",
                                want.res_num, want.res_den, want.status,
                                result.res_num, result.res_den, result.status);
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(reduce_fraction(operands));
        end
    end

    initial begin
        fail_count = 0;
        results_seen = 0;
    end
endmodule

@@ bench/rational_arithmetic_reduce_tb.sv @@
// Testbench top: clock, reset, operand stimulus and the final verdict.
module rational_arithmetic_reduce_tb;
    import rar_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       start = 0;
    in_beat_t   operands = '0;
    logic       busy, done;
    out_beat_t  result;
    int         fail_count, pending, results_seen;
    int         idle_pct;
    int         quiet_cycles = 0;
    int         beats_sent = 0;

    always #5 clk = ~clk;

    rational_arithmetic_reduce uut (
        .clk(clk), .rst_n(rst_n), .start(start), .operands(operands),
        .busy(busy), .done(done), .result(result)
    );

    rational_arithmetic_reduce_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .operands(operands),
        .done(done), .result(result), .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen)
    );

    always @(posedge clk) begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("rational_arithmetic_reduce verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(signed'($urandom_range(0, 6)) - 3);
            3, 4: return 32'(signed'($urandom_range(0, 200)) - 100);
            5: return 32'(signed'($urandom_range(0, 20000)) - 10000);
            default: return $urandom;
        endcase
    endfunction

    // Drive one beat and hold it until the block takes it.
    task automatic send_beat(in_beat_t b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        operands <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beats_sent++;
    endtask

    function automatic in_beat_t make_beat(cmd_t c, int an, int ad, int bn, int bd);
        in_beat_t b;
        b.command = c;
        b.a_num = an;
        b.a_den = ad;
        b.b_num = bn;
        b.b_den = bd;
        return b;
    endfunction

    initial begin
        in_beat_t b;
        int minv;
        minv = 32'h8000_0000;
        idle_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: each command, zero denominators, zero numerators, extremes
        send_beat(make_beat(CMD_ADD, 1, 2, 1, 3));
        send_beat(make_beat(CMD_SUB, 1, 2, 1, 2));
        send_beat(make_beat(CMD_MUL, -3, 4, 8, -9));
        send_beat(make_beat(CMD_DIV, 2, 3, -4, 5));
        send_beat(make_beat(CMD_ADD, 1, 0, 1, 1));
        send_beat(make_beat(CMD_MUL, 1, 1, 1, 0));
        send_beat(make_beat(CMD_DIV, 5, 7, 0, 3));
        send_beat(make_beat(CMD_MUL, 0, -5, 3, 7));
        send_beat(make_beat(CMD_ADD, 0, 5, 0, -7));
        send_beat(make_beat(CMD_MUL, minv, 1, minv, 1));
        send_beat(make_beat(CMD_DIV, minv, 1, -1, 1));
        send_beat(make_beat(CMD_MUL, minv, -1, 1, 1));
        send_beat(make_beat(CMD_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1));
        send_beat(make_beat(CMD_SUB, minv, minv, minv, minv));
        send_beat(make_beat(CMD_ADD, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe));
        send_beat(make_beat(CMD_DIV, minv, 32'h7fff_ffff, minv, 32'h7fff_ffff));
        send_beat(make_beat(CMD_SUB, 32'h7fff_ffff, minv, minv, 32'h7fff_ffff));
        send_beat(make_beat(CMD_MUL, -1, -1, -1, -1));
        // hold until every expected result is back
        start <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 88;
                2: idle_pct = 33;
                default: idle_pct = 0;
            endcase
            for (int i = 0; i < 135; i++) begin
                b.command = 2'($urandom_range(0, 3));
                b.a_num = pick_value();
                b.a_den = pick_value();
                b.b_num = pick_value();
                b.b_den = pick_value();
                // switch the idle chance between 0 and 50 percent every 40 beats
                if (phase == 3 && i % 40 == 0)
                    idle_pct = idle_pct == 0 ? 50 : 0;
                send_beat(b);
            end
        end
        start <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d operand beats over four idle phases, %0d results checked",
            beats_sent, results_seen);
        if (fail_count == 0)
            $display("rational_arithmetic_reduce verification clean");
        else
            $display("rational_arithmetic_reduce verification failed");
        $finish;
    end
endmodule
